>>> hw/rtl/assert_macros.svh
// assertion macros used by the scheduler datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/pts_pkg.sv
// package for the priority timeslice scheduler: types, codes, constants
// no dependencies
`timescale 1ns / 1ps
package pts_pkg;
  localparam int DefMaxThreads = 16;
  localparam int DefPrioLevels = 16;
  localparam int SlotW = 4;
  localparam int PrioW = 5;
  localparam int StampW = 32;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_SLEEP = 3'd2;
  localparam logic [2:0] OP_WAKE = 3'd3;
  localparam logic [2:0] OP_EXIT = 3'd4;
  localparam logic [2:0] OP_SETPRIO = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic CFG_DEF_PRIO = 1'b0;
  localparam logic CFG_MIN_PRIO = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN1, S_EXEC, S_SCAN2, S_PICK, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input transaction
    logic scan_clr; // start a scan
    logic scan_step;
    logic exec;     // apply the event update
    logic pick;     // commit the schedule choice
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic need_pick;
  } sts_t;
endpackage

>>> hw/rtl/pts_if.sv
// valid/ready channel interfaces for the scheduler
// depends on pts_pkg
`timescale 1ns / 1ps
interface pts_in_if import pts_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic [SlotW-1:0] target_thread;
  logic [PrioW-1:0] new_priority;
  modport source (output valid, opcode, target_thread, new_priority, input ready);
  modport sink (input valid, opcode, target_thread, new_priority, output ready);
endinterface

interface pts_out_if import pts_pkg::*; ();
  logic valid;
  logic ready;
  logic [SlotW-1:0] running_thread;
  logic [SlotW-1:0] created_thread;
  logic [1:0] status;
  modport source (output valid, running_thread, created_thread, status, input ready);
  modport sink (input valid, running_thread, created_thread, status, output ready);
endinterface

interface pts_cfg_if import pts_pkg::*; ();
  logic valid;
  logic ready;
  logic index;
  logic [PrioW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pts_ctrl.sv
// scheduler controller state machine
// depends on pts_pkg
`timescale 1ns / 1ps
module pts_ctrl import pts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt = S_SCAN2;
      end
      S_SCAN2: begin
        if (!sts.need_pick) state_nxt = S_OUT;
        else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule

>>> hw/rtl/pts_dp.sv
// scheduler datapath: slot table, serial scans, event update
// depends on pts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pts_dp import pts_pkg::*; #(
  parameter int MAX_THREADS = DefMaxThreads,
  parameter int PRIO_LEVELS = DefPrioLevels
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic [2:0] in_opcode,
  input  logic [SlotW-1:0] in_target,
  input  logic [PrioW-1:0] in_newprio,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic [PrioW-1:0] cfg_data,
  output logic [SlotW-1:0] out_running,
  output logic [SlotW-1:0] out_created,
  output logic [1:0] out_status
);
  localparam int IdxW = $clog2(MAX_THREADS);
  localparam int LvW = $clog2(PRIO_LEVELS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_THREADS - 1);

  logic [MAX_THREADS-1:0] live_r, queued_r, side_r;
  logic [PrioW-1:0] prio_r [MAX_THREADS];
  logic [PrioW-1:0] ts_r [MAX_THREADS];
  logic [LvW-1:0] lvl_r [MAX_THREADS];
  logic [StampW-1:0] stamp_r [MAX_THREADS];
  logic act_r;
  logic [IdxW-1:0] cur_r;
  logic [StampW-1:0] cnt_r;
  logic [PrioW-1:0] defp_r, minp_r;

  logic [2:0] op_r;
  logic [SlotW-1:0] tgt_r;
  logic [PrioW-1:0] np_r;
  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] free_r;
  logic free_found_r;
  logic has_act, has_exp;
  logic found_r;
  logic [IdxW-1:0] best_r;
  logic [LvW-1:0] best_lv_r;
  logic [StampW-1:0] best_st_r;
  logic need_pick_r;
  logic [IdxW-1:0] created_r;
  logic [1:0] status_r;

  function automatic logic [LvW-1:0] clamp_lv(input logic [PrioW:0] v);
    logic [LvW-1:0] r;
    if (v < (PrioW+1)'(1)) r = LvW'(1);
    else if (32'(v) > PRIO_LEVELS) r = LvW'(PRIO_LEVELS);
    else r = LvW'(v);
    return r;
  endfunction

  // pick uses the side that will be active after the swap decision
  logic pick_side;
  assign pick_side = has_act ? act_r : ~act_r;

  logic cand;
  assign cand = (idx_r != '0) && queued_r[idx_r] && (side_r[idx_r] == pick_side);

  logic tgt_ok;
  assign tgt_ok = (tgt_r != '0) && (32'(tgt_r) < MAX_THREADS) &&
                  live_r[IdxW'(tgt_r)] && !queued_r[IdxW'(tgt_r)];

  logic [PrioW+1:0] ts_calc;
  logic [PrioW-1:0] ts_fin;
  always_comb begin
    ts_calc = {2'b0, np_r} - {2'b0, prio_r[cur_r]} + {2'b0, ts_r[cur_r]};
    if ($signed(ts_calc) < $signed({2'b0, minp_r})) ts_calc = {2'b0, minp_r};
    if ($signed(ts_calc) < 1) ts_calc = (PrioW+2)'(1);
    if ($signed(ts_calc) > 31) ts_calc = (PrioW+2)'(31);
    ts_fin = ts_calc[PrioW-1:0];
  end

  logic [PrioW-1:0] cr_prio;
  assign cr_prio = PrioW'(clamp_lv({1'b0, (cur_r == '0) ? defp_r : prio_r[cur_r]}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= MAX_THREADS'(1);
      queued_r <= '0;
      side_r <= '0;
      act_r <= 1'b0;
      cur_r <= '0;
      cnt_r <= '0;
      defp_r <= PrioW'(8);
      minp_r <= PrioW'(1);
      need_pick_r <= 1'b0;
      created_r <= '0;
      status_r <= ST_DONE;
      for (int i = 0; i < MAX_THREADS; i++) begin
        prio_r[i] <= '0;
        ts_r[i] <= '0;
        lvl_r[i] <= '0;
        stamp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_DEF_PRIO) defp_r <= cfg_data;
        else minp_r <= cfg_data;
      end
      if (cmd.exec) begin
        status_r <= ST_DONE;
        created_r <= '0;
        need_pick_r <= 1'b0;
        case (op_r)
          OP_TICK: begin
            if (cur_r == '0) need_pick_r <= 1'b1;
            else if (ts_r[cur_r] <= PrioW'(1)) begin
              ts_r[cur_r] <= prio_r[cur_r];
              cnt_r <= cnt_r + 1'b1;
              queued_r[cur_r] <= 1'b1;
              side_r[cur_r] <= ~act_r;
              lvl_r[cur_r] <= clamp_lv({1'b0, prio_r[cur_r]});
              stamp_r[cur_r] <= cnt_r + 1'b1;
              need_pick_r <= 1'b1;
            end else ts_r[cur_r] <= ts_r[cur_r] - 1'b1;
          end
          OP_CREATE: begin
            if (!free_found_r) status_r <= ST_FULL;
            else begin
              live_r[free_r] <= 1'b1;
              prio_r[free_r] <= cr_prio;
              ts_r[free_r] <= cr_prio;
              cnt_r <= cnt_r + 1'b1;
              queued_r[free_r] <= 1'b1;
              side_r[free_r] <= act_r;
              lvl_r[free_r] <= clamp_lv({1'b0, cr_prio});
              stamp_r[free_r] <= cnt_r + 1'b1;
              created_r <= free_r;
            end
          end
          OP_SLEEP, OP_EXIT: begin
            if (cur_r == '0) status_r <= ST_REFUSED;
            else begin
              queued_r[cur_r] <= 1'b0;
              if (op_r == OP_EXIT) live_r[cur_r] <= 1'b0;
              need_pick_r <= 1'b1;
            end
          end
          OP_WAKE: begin
            if (!tgt_ok) status_r <= ST_REFUSED;
            else begin
              cnt_r <= cnt_r + 1'b1;
              queued_r[IdxW'(tgt_r)] <= 1'b1;
              side_r[IdxW'(tgt_r)] <= act_r;
              lvl_r[IdxW'(tgt_r)] <= clamp_lv({1'b0, ts_r[IdxW'(tgt_r)]});
              stamp_r[IdxW'(tgt_r)] <= cnt_r + 1'b1;
            end
          end
          OP_SETPRIO: begin
            if (cur_r == '0 || np_r == '0 || 32'(np_r) > PRIO_LEVELS)
              status_r <= ST_REFUSED;
            else begin
              ts_r[cur_r] <= ts_fin;
              prio_r[cur_r] <= np_r;
              cnt_r <= cnt_r + 1'b1;
              queued_r[cur_r] <= 1'b1;
              side_r[cur_r] <= act_r;
              lvl_r[cur_r] <= clamp_lv({1'b0, ts_fin});
              stamp_r[cur_r] <= cnt_r + 1'b1;
            end
          end
          default: status_r <= ST_REFUSED;
        endcase
      end
      if (cmd.pick) begin
        if (!has_act && !has_exp) cur_r <= '0;
        else begin
          act_r <= pick_side;
          cur_r <= found_r ? best_r : '0;
        end
      end
    end
  end

  // input capture; scan: free slot search in the first pass, best pick in the second; output load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      tgt_r <= in_target;
      np_r <= in_newprio;
    end
    if (cmd.scan_clr) begin
      idx_r <= '0;
      free_found_r <= 1'b0;
      free_r <= '0;
      found_r <= 1'b0;
      best_r <= '0;
      best_lv_r <= '0;
      best_st_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r != '0 && !live_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r <= idx_r;
      end
      if (cand && (!found_r || lvl_r[idx_r] > best_lv_r ||
          (lvl_r[idx_r] == best_lv_r && stamp_r[idx_r] > best_st_r))) begin
        found_r <= 1'b1;
        best_r <= idx_r;
        best_lv_r <= lvl_r[idx_r];
        best_st_r <= stamp_r[idx_r];
      end
    end
    if (cmd.out_load) begin
      out_running <= SlotW'(cur_r);
      out_created <= SlotW'(created_r);
      out_status <= status_r;
    end
  end

  // side occupancy is a reduction over flag vectors, seen after the event update
  logic [MAX_THREADS-1:0] q_nz;
  assign q_nz = queued_r & ~MAX_THREADS'(1);
  assign has_act = |(q_nz & (act_r ? side_r : ~side_r));
  assign has_exp = |(q_nz & (act_r ? ~side_r : side_r));

  assign sts.scan_last = (idx_r == LastIdx);
  assign sts.need_pick = need_pick_r;

  `ASSERT_IMPL(a_idle_live, clk, rst_n, 1'b1, live_r[0])
  `ASSERT_IMPL(a_cur_live, clk, rst_n, 1'b1, live_r[cur_r] || need_pick_r)
  `ASSERT_NEXT(a_pick_found, clk, rst_n, cmd.pick && found_r, cur_r != '0)
endmodule

>>> hw/rtl/priority_timeslice_scheduler.sv
// priority timeslice scheduler: one event in, one result out
// an event is taken only when idle; it runs a first serial pass over the slots, the event update
// and, when a reschedule is needed, a second serial pass and the pick, before the result
// is loaded; a stalled result holds back the next event
// reset: rst_n synchronous active low; only idle slot 0 live, idle running
// depends on pts_pkg, pts_if, pts_ctrl, pts_dp
`timescale 1ns / 1ps
module priority_timeslice_scheduler import pts_pkg::*; #(
  parameter int MAX_THREADS = DefMaxThreads,
  parameter int PRIO_LEVELS = DefPrioLevels
) (
  input logic clk,
  input logic rst_n,
  pts_in_if.sink in_ch,
  pts_out_if.source out_ch,
  pts_cfg_if.sink cfg_ch
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  pts_dp #(.MAX_THREADS(MAX_THREADS), .PRIO_LEVELS(PRIO_LEVELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_ch.opcode), .in_target(in_ch.target_thread),
    .in_newprio(in_ch.new_priority),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .out_running(out_ch.running_thread), .out_created(out_ch.created_thread),
    .out_status(out_ch.status)
  );
endmodule
